[rtl/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants
// Widths, register indexes, state types and lane handshake structs for the
// gamepad report conditioner.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int FRAC_BITS = 15;
  localparam int AXIS_FULL_SCALE = 32767;

  localparam int BTN_W  = 16;
  localparam int PKT_W  = 32;
  localparam int TRIG_W = 8;
  localparam int AXIS_W = 16;
  localparam int DZ_W   = 15;
  localparam int DIR_W  = 17;
  localparam int OMAG_W = 16;
  localparam int CFG_W  = 15;
  localparam int CFG_IDX_W = 2;

  localparam int SQ_W       = 2 * AXIS_W;
  localparam int ROOT_IN_W  = 2 * SQ_W;
  localparam int ROOT_W     = SQ_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam int DIV_NW    = FRAC_BITS + 32;
  localparam int DIV_DW    = 32;
  localparam int DIV_QW    = FRAC_BITS + 2;
  localparam int DIV_CNT_W = $clog2(DIV_QW);

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DEAD_ZONE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DEAD_ZONE   = 2'd2;

  localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd30;
  localparam logic [DZ_W-1:0]   LDZ_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0]   RDZ_RESET  = 15'd8689;

  typedef enum logic {T_IDLE, T_BUSY} top_state_t;
  typedef enum logic [2:0] {L_IDLE, L_MUL, L_CMP, L_ROOT, L_DIV, L_DONE} lane_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
  } lane_sts_t;

endpackage

[rtl/grc_ifs.sv]
// ----------------------------------------------------------------------------
// grc_ifs: report and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface grc_report_if;
  import grc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     connected;
  logic [PKT_W-1:0]         packet_number;
  logic [BTN_W-1:0]         button_word;
  logic [TRIG_W-1:0]        left_trigger_level;
  logic [TRIG_W-1:0]        right_trigger_level;
  logic signed [AXIS_W-1:0] left_stick_x;
  logic signed [AXIS_W-1:0] left_stick_y;
  logic signed [AXIS_W-1:0] right_stick_x;
  logic signed [AXIS_W-1:0] right_stick_y;

  modport source (output valid, connected, packet_number, button_word, left_trigger_level,
                  right_trigger_level, left_stick_x, left_stick_y, right_stick_x,
                  right_stick_y, input ready);
  modport sink (input valid, connected, packet_number, button_word, left_trigger_level,
                right_trigger_level, left_stick_x, left_stick_y, right_stick_x,
                right_stick_y, output ready);
endinterface

interface grc_result_if;
  import grc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [BTN_W-1:0]        held_mask;
  logic [BTN_W-1:0]        pressed_edge_mask;
  logic signed [DIR_W-1:0] left_dir_x;
  logic signed [DIR_W-1:0] left_dir_y;
  logic [OMAG_W-1:0]       left_magnitude;
  logic signed [DIR_W-1:0] right_dir_x;
  logic signed [DIR_W-1:0] right_dir_y;
  logic [OMAG_W-1:0]       right_magnitude;

  modport source (output valid, held_mask, pressed_edge_mask, left_dir_x, left_dir_y,
                  left_magnitude, right_dir_x, right_dir_y, right_magnitude, input ready);
  modport sink (input valid, held_mask, pressed_edge_mask, left_dir_x, left_dir_y,
                left_magnitude, right_dir_x, right_dir_y, right_magnitude, output ready);
endinterface

[rtl/grc_isqrt.sv]
// ----------------------------------------------------------------------------
// grc_isqrt: iterative integer square root
// One result bit per cycle; fin pulses once when the root is complete.
// ----------------------------------------------------------------------------
module grc_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [grc_pkg::ROOT_IN_W-1:0]  value,
  output logic [grc_pkg::ROOT_W-1:0]     root,
  output logic                           fin
);
  import grc_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [ROOT_IN_W-1:0]  val_r;
  logic [REM_W-1:0]      rem_r, rem_nxt, remt, trial;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r, fin_r, ge;

  always_comb begin
    remt     = {rem_r[REM_W-3:0], val_r[ROOT_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = remt >= trial;
    rem_nxt  = ge ? remt - trial : remt;
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        val_r  <= value;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        val_r  <= val_r << 2;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;
  assign fin  = fin_r;
endmodule

[rtl/grc_div.sv]
// ----------------------------------------------------------------------------
// grc_div: restoring divider
// One quotient bit per cycle. The quotient must fit DIV_QW bits.
// ----------------------------------------------------------------------------
module grc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [grc_pkg::DIV_NW-1:0]  num,
  input  logic [grc_pkg::DIV_DW-1:0]  den,
  output logic [grc_pkg::DIV_QW-1:0]  quo,
  output logic                        fin
);
  import grc_pkg::*;

  logic [DIV_DW-1:0]    rem_r, den_r;
  logic [DIV_QW-1:0]    lo_r, q_r;
  logic [DIV_DW:0]      r2;
  logic                 ge, busy_r, fin_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  always_comb begin
    r2 = {rem_r, lo_r[DIV_QW-1]};
    ge = r2 >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        rem_r  <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
        lo_r   <= num[DIV_QW-1:0];
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DIV_DW'(r2 - {1'b0, den_r}) : r2[DIV_DW-1:0];
        lo_r  <= lo_r << 1;
        q_r   <= {q_r[DIV_QW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_QW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;
  assign fin = fin_r;
endmodule

[rtl/grc_stick.sv]
// ----------------------------------------------------------------------------
// grc_stick: one stick lane
// Radial dead zone, radius by square root, unit direction and rescaled
// magnitude by three dividers working side by side.
// ----------------------------------------------------------------------------
module grc_stick (
  input  logic                               clk,
  input  logic                               rst_n,
  input  grc_pkg::lane_ctl_t                 ctl,
  output grc_pkg::lane_sts_t                 sts,
  input  logic signed [grc_pkg::AXIS_W-1:0]  x,
  input  logic signed [grc_pkg::AXIS_W-1:0]  y,
  input  logic [grc_pkg::DZ_W-1:0]           dz,
  output logic signed [grc_pkg::DIR_W-1:0]   dir_x,
  output logic signed [grc_pkg::DIR_W-1:0]   dir_y,
  output logic [grc_pkg::OMAG_W-1:0]         mag
);
  import grc_pkg::*;

  localparam logic [ROOT_W-1:0] CAP = ROOT_W'(AXIS_FULL_SCALE) << 16;

  lane_state_t st_r, st_nxt;

  logic [AXIS_W-1:0]   ax_r, ay_r;
  logic                nx_r, ny_r;
  logic [DZ_W-1:0]     dz_r;
  logic [SQ_W-1:0]     ax2_r, ay2_r, s;
  logic [2*DZ_W-1:0]   dz2_r;
  logic                outside;
  logic                root_go, div_go;
  logic [ROOT_W-1:0]   r, mc, mnum;
  logic                root_fin, dx_fin, dy_fin, dm_fin;
  logic [DZ_W-1:0]     den15;
  logic [DIV_DW-1:0]   mden;
  logic [DIV_QW-1:0]   qx, qy, qm;
  logic signed [DIR_W-1:0] dx_r, dy_r;
  logic [OMAG_W-1:0]   mag_r;

  always_comb begin
    s       = ax2_r + ay2_r;
    outside = s > SQ_W'(dz2_r);
    mc      = (r > CAP) ? CAP : r;
    mnum    = mc - {1'b0, dz_r, 16'b0};
    den15   = DZ_W'(AXIS_FULL_SCALE) - dz_r;
    mden    = {1'b0, den15, 16'b0};
  end

  always_comb begin
    st_nxt  = st_r;
    root_go = 1'b0;
    div_go  = 1'b0;
    unique case (st_r)
      L_IDLE: if (ctl.start) st_nxt = L_MUL;
      L_MUL:  st_nxt = L_CMP;
      L_CMP: begin
        if (outside) begin
          root_go = 1'b1;
          st_nxt  = L_ROOT;
        end else begin
          st_nxt = L_DONE;
        end
      end
      L_ROOT: begin
        if (root_fin) begin
          div_go = 1'b1;
          st_nxt = L_DIV;
        end
      end
      L_DIV:  if (dx_fin) st_nxt = L_DONE;
      L_DONE: if (ctl.ack) st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= L_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_r == L_IDLE && ctl.start) begin
      nx_r <= x[AXIS_W-1];
      ny_r <= y[AXIS_W-1];
      ax_r <= x[AXIS_W-1] ? AXIS_W'(-x) : AXIS_W'(x);
      ay_r <= y[AXIS_W-1] ? AXIS_W'(-y) : AXIS_W'(y);
      dz_r <= dz;
    end
    if (st_r == L_MUL) begin
      ax2_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      ay2_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
      dz2_r <= (2*DZ_W)'(dz_r) * (2*DZ_W)'(dz_r);
    end
    if (st_r == L_CMP && !outside) begin
      dx_r  <= '0;
      dy_r  <= '0;
      mag_r <= '0;
    end
    if (st_r == L_DIV && dx_fin) begin
      dx_r  <= nx_r ? DIR_W'(-DIR_W'(qx)) : DIR_W'(qx);
      dy_r  <= ny_r ? DIR_W'(-DIR_W'(qy)) : DIR_W'(qy);
      mag_r <= (den15 == '0) ? OMAG_W'(1 << FRAC_BITS) : OMAG_W'(qm);
    end
  end

  grc_isqrt u_root (
    .clk(clk), .rst_n(rst_n), .start(root_go),
    .value({s, {SQ_W{1'b0}}}), .root(r), .fin(root_fin)
  );

  grc_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(DIV_NW'(ax_r) << (FRAC_BITS + 16)), .den(r), .quo(qx), .fin(dx_fin)
  );

  grc_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(DIV_NW'(ay_r) << (FRAC_BITS + 16)), .den(r), .quo(qy), .fin(dy_fin)
  );

  grc_div u_div_m (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(DIV_NW'(mnum) << FRAC_BITS), .den(mden), .quo(qm), .fin(dm_fin)
  );

  assign sts.done = (st_r == L_DONE);
  assign dir_x    = dx_r;
  assign dir_y    = dy_r;
  assign mag      = mag_r;

  property p_div_lockstep;
    @(posedge clk) disable iff (!rst_n) dx_fin |-> (dy_fin && dm_fin);
  endproperty
  a_div_lockstep: assert property (p_div_lockstep) else $error("dividers out of step");
endmodule

[rtl/gamepad_report_conditioner.sv]
// ----------------------------------------------------------------------------
// gamepad_report_conditioner: controller report conditioning
// Button held/edge masks, trigger thresholds and radial stick dead zones.
// ----------------------------------------------------------------------------
// A report with a new packet number is worked in these steps after its transfer:
// square and compare against the dead zone, then each lane's bit-serial square
// root, start the lane dividers, run the dividers, register the lane result and
// merge it into the output register. Both sticks run in parallel lanes; a stick
// inside its dead zone skips the square root and its dividers. Disconnected and
// repeated reports need no stick work and give their result in the cycle after
// transfer. One report is in work at a time; a new report is taken only while the
// output register is empty or being emptied in the same cycle, so a stalled result
// holds off input.
module gamepad_report_conditioner (
  input  logic                            clk,
  input  logic                            rst_n,
  grc_report_if.sink                      in_rpt,
  grc_result_if.source                    out_res,
  input  logic                            cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grc_pkg::CFG_W-1:0]       cfg_data
);
  import grc_pkg::*;

  top_state_t st_r, st_nxt;

  logic [TRIG_W-1:0] thr_r;
  logic [DZ_W-1:0]   ldz_r, rdz_r;
  logic [BTN_W-1:0]  held_r, held_nxt, edge_r, edge_nxt, now;
  logic [PKT_W-1:0]  last_r, last_nxt;
  logic              dirty_r, dirty_nxt;
  logic signed [DIR_W-1:0] lx_r, ly_r, rx_r, ry_r, lx_nxt, ly_nxt, rx_nxt, ry_nxt;
  logic [OMAG_W-1:0] lm_r, rm_r, lm_nxt, rm_nxt;
  logic signed [DIR_W-1:0] l_dx, l_dy, r_dx, r_dy;
  logic [OMAG_W-1:0] l_mag, r_mag;
  logic              out_valid_r, out_free, in_fire, load_out;
  lane_ctl_t         lane_ctl;
  lane_sts_t         l_sts, r_sts;

  assign out_free     = !out_valid_r || out_res.ready;
  assign in_rpt.ready = (st_r == T_IDLE) && out_free;
  assign in_fire      = in_rpt.valid && in_rpt.ready;

  always_comb begin
    now     = '0;
    now[0]  = in_rpt.button_word[0];
    now[1]  = in_rpt.button_word[1];
    now[2]  = in_rpt.button_word[2];
    now[3]  = in_rpt.button_word[3];
    now[4]  = in_rpt.button_word[4];
    now[5]  = in_rpt.button_word[5];
    now[6]  = in_rpt.button_word[8];
    now[7]  = in_rpt.left_trigger_level > thr_r;
    now[8]  = in_rpt.button_word[6];
    now[9]  = in_rpt.button_word[9];
    now[10] = in_rpt.right_trigger_level > thr_r;
    now[11] = in_rpt.button_word[7];
    now[15:12] = in_rpt.button_word[15:12];
  end

  always_comb begin
    st_nxt    = st_r;
    held_nxt  = held_r;
    edge_nxt  = edge_r;
    last_nxt  = last_r;
    dirty_nxt = dirty_r;
    lx_nxt = lx_r; ly_nxt = ly_r; lm_nxt = lm_r;
    rx_nxt = rx_r; ry_nxt = ry_r; rm_nxt = rm_r;
    load_out  = 1'b0;
    lane_ctl  = '0;
    unique case (st_r)
      T_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          if (!in_rpt.connected) begin
            if (dirty_r) begin
              held_nxt  = '0;
              edge_nxt  = '0;
              dirty_nxt = 1'b0;
              lx_nxt = '0; ly_nxt = '0; lm_nxt = '0;
              rx_nxt = '0; ry_nxt = '0; rm_nxt = '0;
            end
          end else if (in_rpt.packet_number == last_r) begin
            edge_nxt = '0;
          end else begin
            last_nxt  = in_rpt.packet_number;
            dirty_nxt = 1'b1;
            edge_nxt  = now & ~held_r;
            held_nxt  = now;
            load_out  = 1'b0;
            lane_ctl.start = 1'b1;
            st_nxt    = T_BUSY;
          end
        end
      end
      T_BUSY: begin
        if (l_sts.done && r_sts.done && out_free) begin
          lx_nxt = l_dx; ly_nxt = l_dy; lm_nxt = l_mag;
          rx_nxt = r_dx; ry_nxt = r_dy; rm_nxt = r_mag;
          load_out     = 1'b1;
          lane_ctl.ack = 1'b1;
          st_nxt       = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= TRIG_RESET;
      ldz_r       <= LDZ_RESET;
      rdz_r       <= RDZ_RESET;
      held_r      <= '0;
      edge_r      <= '0;
      last_r      <= '0;
      dirty_r     <= 1'b0;
      lx_r <= '0; ly_r <= '0; lm_r <= '0;
      rx_r <= '0; ry_r <= '0; rm_r <= '0;
    end else begin
      st_r    <= st_nxt;
      held_r  <= held_nxt;
      edge_r  <= edge_nxt;
      last_r  <= last_nxt;
      dirty_r <= dirty_nxt;
      lx_r <= lx_nxt; ly_r <= ly_nxt; lm_r <= lm_nxt;
      rx_r <= rx_nxt; ry_r <= ry_nxt; rm_r <= rm_nxt;
      if (load_out)           out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TRIGGER_THRESHOLD: thr_r <= cfg_data[TRIG_W-1:0];
          CFG_LEFT_DEAD_ZONE:    ldz_r <= cfg_data[DZ_W-1:0];
          CFG_RIGHT_DEAD_ZONE:   rdz_r <= cfg_data[DZ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res.held_mask         <= held_nxt;
      out_res.pressed_edge_mask <= edge_nxt;
      out_res.left_dir_x        <= lx_nxt;
      out_res.left_dir_y        <= ly_nxt;
      out_res.left_magnitude    <= lm_nxt;
      out_res.right_dir_x       <= rx_nxt;
      out_res.right_dir_y       <= ry_nxt;
      out_res.right_magnitude   <= rm_nxt;
    end
  end

  assign out_res.valid = out_valid_r;

  grc_stick u_left (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .sts(l_sts),
    .x(in_rpt.left_stick_x), .y(in_rpt.left_stick_y), .dz(ldz_r),
    .dir_x(l_dx), .dir_y(l_dy), .mag(l_mag)
  );

  grc_stick u_right (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .sts(r_sts),
    .x(in_rpt.right_stick_x), .y(in_rpt.right_stick_y), .dz(rdz_r),
    .dir_x(r_dx), .dir_y(r_dy), .mag(r_mag)
  );

  property p_new_packet_busy;
    @(posedge clk) disable iff (!rst_n)
      (in_fire && in_rpt.connected && (in_rpt.packet_number != last_r)) |=> (st_r == T_BUSY);
  endproperty
  a_new_packet_busy: assert property (p_new_packet_busy) else $error("new packet not started");

  property p_clean_when_not_dirty;
    @(posedge clk) disable iff (!rst_n)
      !dirty_r |-> (held_r == '0) && (edge_r == '0) && (lm_r == '0) && (rm_r == '0);
  endproperty
  a_clean_when_not_dirty: assert property (p_clean_when_not_dirty)
    else $error("state left over while clean");

  property p_edge_within_held;
    @(posedge clk) disable iff (!rst_n) (edge_r & ~held_r) == '0;
  endproperty
  a_edge_within_held: assert property (p_edge_within_held) else $error("edge without hold");

  property p_load_only_when_free;
    @(posedge clk) disable iff (!rst_n) load_out |-> out_free;
  endproperty
  a_load_only_when_free: assert property (p_load_only_when_free)
    else $error("result overwritten before transfer");
endmodule
